FILE: hdl/swsm_pkg.sv
// Shared types and constants of the spill word stream monitor.
package swsm_pkg;

   localparam int WORD_W               = 32;
   localparam int TAG_W                = 12;
   localparam int PEND_W               = 21;
   localparam int TOTAL_W              = 32;
   localparam int STEP_W               = 4;
   localparam int NUM_PEND             = 5;
   localparam int QUEUE_DEPTH          = 2;
   localparam int STATUS_WORDS_DEFAULT = 8;

   localparam logic [WORD_W-1:0] WORD_RO   = 32'h5C5C5C5C;
   localparam logic [WORD_W-1:0] WORD_FH   = 32'h1C1C1C1C;
   localparam logic [WORD_W-1:0] WORD_CRC  = 32'h9C9C9C9C;
   localparam logic [WORD_W-1:0] WORD_SH   = 32'h7C7C7C7C;
   localparam logic [3:0]        SOS_NIBBLE = 4'h7;
   localparam logic [3:0]        EOS_NIBBLE = 4'hF;

   localparam logic [PEND_W-1:0]  PEND_MAX  = {PEND_W{1'b1}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // Pending counter slots
   localparam int P_RO    = 0;
   localparam int P_FH    = 1;
   localparam int P_CRC   = 2;
   localparam int P_SH    = 3;
   localparam int P_UPSET = 4;

   typedef enum logic [3:0] {
      CLS_SOS         = 4'd0,
      CLS_MISSING_SOS = 4'd1,
      CLS_ROLLOVER    = 4'd2,
      CLS_FRAME       = 4'd3,
      CLS_CRC         = 4'd4,
      CLS_STATUS_HDR  = 4'd5,
      CLS_STATUS_OK   = 4'd6,
      CLS_UPSET       = 4'd7,
      CLS_EOS         = 4'd8,
      CLS_DATA        = 4'd9
   } class_type;

   // Classified item handed from the front to the back
   typedef struct packed {
      class_type           cls;
      logic [TAG_W-1:0]    tag;
      logic                clear;       // new spill: drop pending counts first
      logic                start_ok;    // bump spills started
      logic [NUM_PEND-1:0] inc;         // pending increments before any commit
      logic                commit;      // fold pending into totals
      logic                upset_post;  // upset increment after the commit
      logic                end_first;   // bump spills ended
      logic                missing;
      logic                last;        // drop pending counts at the end
   } item_type;

endpackage

FILE: hdl/swsm_front.sv
// Front stage: tracks spill framing and classifies each readout word.
module swsm_front #(
   parameter int STATUS_WORDS = swsm_pkg::STATUS_WORDS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [swsm_pkg::WORD_W-1:0] word,
   input  logic                        first_of_spill,
   input  logic                        last_of_spill,
   output swsm_pkg::item_type          item
);

   localparam int STEP_W = swsm_pkg::STEP_W;
   localparam int TAG_W  = swsm_pkg::TAG_W;

   logic [1:0]       pos_ff, pos_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic             end_seen_ff, end_seen_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic                        start;
   logic                        is_end;
   logic                        upset;
   logic [STEP_W:0]             step_next;
   logic [swsm_pkg::WORD_W-1:0] end_word;

   assign start     = first_of_spill || (pos_ff == 2'd0);
   assign end_word  = {swsm_pkg::EOS_NIBBLE, tag_ff, 16'h0000};
   assign step_next = {1'b0, step_ff} + {{STEP_W{1'b0}}, 1'b1};
   assign upset     = (word[3:0] != 4'h0);

   always_comb begin
      item        = '0;
      item.cls    = swsm_pkg::CLS_DATA;
      item.tag    = tag_ff;
      item.last   = last_of_spill;
      pos_in      = pos_ff;
      tag_in      = tag_ff;
      end_seen_in = end_seen_ff;
      step_in     = step_ff;
      is_end      = 1'b0;

      if (start) begin
         item.clear    = 1'b1;
         tag_in        = word[27:16];
         item.tag      = word[27:16];
         end_seen_in   = 1'b0;
         step_in       = '0;
         pos_in        = 2'd0;
         item.start_ok = (word[31:28] == swsm_pkg::SOS_NIBBLE);
         item.cls      = item.start_ok ? swsm_pkg::CLS_SOS : swsm_pkg::CLS_MISSING_SOS;
      end else if (word == swsm_pkg::WORD_RO) begin
         item.cls                   = swsm_pkg::CLS_ROLLOVER;
         item.inc[swsm_pkg::P_RO]   = 1'b1;
         step_in                    = '0;
      end else if (word == swsm_pkg::WORD_FH) begin
         item.cls                   = swsm_pkg::CLS_FRAME;
         item.inc[swsm_pkg::P_FH]   = 1'b1;
         step_in                    = '0;
      end else if (word == swsm_pkg::WORD_CRC) begin
         item.cls                   = swsm_pkg::CLS_CRC;
         item.inc[swsm_pkg::P_CRC]  = 1'b1;
         step_in                    = '0;
      end else if (word == swsm_pkg::WORD_SH) begin
         item.cls                   = swsm_pkg::CLS_STATUS_HDR;
         item.inc[swsm_pkg::P_SH]   = 1'b1;
         step_in                    = {{(STEP_W-1){1'b0}}, 1'b1};
      end else begin
         // end marker counts only from the third word of the spill on
         is_end = (pos_ff == 2'd2) && (word == end_word);
         if (is_end) begin
            item.cls       = swsm_pkg::CLS_EOS;
            item.commit    = 1'b1;
            item.end_first = !end_seen_ff;
            end_seen_in    = 1'b1;
         end
         if ((step_ff != '0) && ({1'b0, step_ff} <= (STEP_W+1)'(STATUS_WORDS))) begin
            if (upset) begin
               if (is_end) begin
                  item.upset_post = 1'b1;
               end else begin
                  item.inc[swsm_pkg::P_UPSET] = 1'b1;
                  item.cls                    = swsm_pkg::CLS_UPSET;
               end
            end else if (!is_end) begin
               item.cls = swsm_pkg::CLS_STATUS_OK;
            end
            step_in = (step_next == (STEP_W+1)'(STATUS_WORDS + 1)) ? '0
                                                                   : step_next[STEP_W-1:0];
         end else begin
            step_in = '0;
         end
      end

      if (pos_in != 2'd2) begin
         pos_in = pos_in + 2'd1;
      end

      if (last_of_spill) begin
         item.missing = !end_seen_in;
         item.commit  = item.commit || !end_seen_in;
         step_in      = '0;
         pos_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 2'd0;
         tag_ff      <= '0;
         end_seen_ff <= 1'b0;
         step_ff     <= '0;
      end else if (push) begin
         pos_ff      <= pos_in;
         tag_ff      <= tag_in;
         end_seen_ff <= end_seen_in;
         step_ff     <= step_in;
      end
   end

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_W'(STATUS_WORDS))
      else $error("status window step beyond window length");

endmodule

FILE: hdl/swsm_queue.sv
// Short queue of classified items between the front and the back.
module swsm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  swsm_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output swsm_pkg::item_type head_item
);

   localparam int DEPTH = swsm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   swsm_pkg::item_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_W'(DEPTH)))
      else $error("queue count beyond depth");

endmodule

FILE: hdl/swsm_back.sv
// Back stage: pending and committed counters and the result register.
module swsm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  swsm_pkg::item_type            head_item,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [3:0]                    rsp_word_class,
   output logic [swsm_pkg::TOTAL_W-1:0]  rsp_rollover_total,
   output logic [swsm_pkg::TOTAL_W-1:0]  rsp_frame_header_total,
   output logic [swsm_pkg::TOTAL_W-1:0]  rsp_crc_header_total,
   output logic [swsm_pkg::TOTAL_W-1:0]  rsp_status_header_total,
   output logic [swsm_pkg::TOTAL_W-1:0]  rsp_upset_total,
   output logic [swsm_pkg::TOTAL_W-1:0]  rsp_spills_started,
   output logic [swsm_pkg::TOTAL_W-1:0]  rsp_spills_ended,
   output logic [swsm_pkg::TAG_W-1:0]    rsp_spill_tag,
   output logic                          rsp_end_missing
);

   localparam int NP = swsm_pkg::NUM_PEND;
   localparam int PW = swsm_pkg::PEND_W;
   localparam int TW = swsm_pkg::TOTAL_W;

   logic [PW-1:0] pend_ff [NP];
   logic [PW-1:0] pend_in [NP];
   logic [TW-1:0] total_ff [NP];
   logic [TW-1:0] total_in [NP];
   logic [TW-1:0] started_ff, started_in;
   logic [TW-1:0] ended_ff, ended_in;

   logic                       valid_ff;
   swsm_pkg::class_type        cls_ff;
   logic [swsm_pkg::TAG_W-1:0] tag_ff;
   logic                       missing_ff;

   logic [PW-1:0] pend_a [NP];
   logic [PW-1:0] pend_b [NP];
   logic [TW:0]   sum    [NP];

   assign pop = head_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      for (int k = 0; k < NP; k++) begin
         pend_a[k] = head_item.clear ? '0 : pend_ff[k];
         pend_b[k] = (head_item.inc[k] && (pend_a[k] != swsm_pkg::PEND_MAX))
                     ? pend_a[k] + PW'(1) : pend_a[k];
         sum[k]    = {1'b0, total_ff[k]} + (TW+1)'(pend_b[k]);
         if (head_item.commit) begin
            total_in[k] = sum[k][TW] ? swsm_pkg::TOTAL_MAX : sum[k][TW-1:0];
            pend_in[k]  = '0;
         end else begin
            total_in[k] = total_ff[k];
            pend_in[k]  = pend_b[k];
         end
         if (head_item.last) begin
            pend_in[k] = '0;
         end
      end
      // upset on the end marker itself lands in the fresh pending set
      if (head_item.upset_post && !head_item.last) begin
         pend_in[swsm_pkg::P_UPSET] = PW'(1);
      end
      started_in = (head_item.start_ok && (started_ff != swsm_pkg::TOTAL_MAX))
                   ? started_ff + TW'(1) : started_ff;
      ended_in   = (head_item.end_first && (ended_ff != swsm_pkg::TOTAL_MAX))
                   ? ended_ff + TW'(1) : ended_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NP; k++) begin
            pend_ff[k]  <= '0;
            total_ff[k] <= '0;
         end
         started_ff <= '0;
         ended_ff   <= '0;
         valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            for (int k = 0; k < NP; k++) begin
               pend_ff[k]  <= pend_in[k];
               total_ff[k] <= total_in[k];
            end
            started_ff <= started_in;
            ended_ff   <= ended_in;
            valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cls_ff     <= head_item.cls;
         tag_ff     <= head_item.tag;
         missing_ff <= head_item.missing;
      end
   end

   assign rsp_valid               = valid_ff;
   assign rsp_word_class          = cls_ff;
   assign rsp_spill_tag           = tag_ff;
   assign rsp_end_missing         = missing_ff;
   assign rsp_rollover_total      = total_ff[swsm_pkg::P_RO];
   assign rsp_frame_header_total  = total_ff[swsm_pkg::P_FH];
   assign rsp_crc_header_total    = total_ff[swsm_pkg::P_CRC];
   assign rsp_status_header_total = total_ff[swsm_pkg::P_SH];
   assign rsp_upset_total         = total_ff[swsm_pkg::P_UPSET];
   assign rsp_spills_started      = started_ff;
   assign rsp_spills_ended        = ended_ff;

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && head_item.last) |=> (pend_ff[swsm_pkg::P_RO] == '0 &&
                                   pend_ff[swsm_pkg::P_UPSET] == '0))
      else $error("pending counts survive spill end");
   a_post_needs_commit: assert property (@(posedge clock) disable iff (reset)
      (pop && (head_item.upset_post || head_item.end_first)) |-> head_item.commit)
      else $error("end marker item without commit");
   a_totals_hold: assert property (@(posedge clock) disable iff (reset)
      (!pop && !$past(reset)) |=> $stable(total_ff[swsm_pkg::P_RO]) && $stable(ended_ff))
      else $error("totals moved without an item");

endmodule

FILE: hdl/spill_word_stream_monitor_core.sv
// Top level of the spill word stream monitor: front, queue and back.
// An accepted word passes through the queue and then the result register before it drives the rsp ports.
// Throughput: one word per cycle; the front only compares, the back does one
// saturating add per counter per word; req_stall rises only once the two-entry
// queue fills behind a stalled result.
// Reset clears framing state, queue and all counters; words are taken right after.
module spill_word_stream_monitor_core #(
   parameter int STATUS_WORDS = swsm_pkg::STATUS_WORDS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [swsm_pkg::WORD_W-1:0]   req_word,
   input  logic                          req_first_of_spill,
   input  logic                          req_last_of_spill,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [3:0]                    rsp_word_class,
   output logic [swsm_pkg::TOTAL_W-1:0]  rsp_rollover_total,
   output logic [swsm_pkg::TOTAL_W-1:0]  rsp_frame_header_total,
   output logic [swsm_pkg::TOTAL_W-1:0]  rsp_crc_header_total,
   output logic [swsm_pkg::TOTAL_W-1:0]  rsp_status_header_total,
   output logic [swsm_pkg::TOTAL_W-1:0]  rsp_upset_total,
   output logic [swsm_pkg::TOTAL_W-1:0]  rsp_spills_started,
   output logic [swsm_pkg::TOTAL_W-1:0]  rsp_spills_ended,
   output logic [swsm_pkg::TAG_W-1:0]    rsp_spill_tag,
   output logic                          rsp_end_missing
);

   logic               push;
   logic               full;
   logic               pop;
   logic               head_valid;
   swsm_pkg::item_type front_item;
   swsm_pkg::item_type head_item;

   assign req_stall = full;
   assign push      = req_valid && !full;

   swsm_front #(
      .STATUS_WORDS(STATUS_WORDS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .word           (req_word),
      .first_of_spill (req_first_of_spill),
      .last_of_spill  (req_last_of_spill),
      .item           (front_item)
   );

   swsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   swsm_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .head_valid              (head_valid),
      .head_item               (head_item),
      .pop                     (pop),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_word_class          (rsp_word_class),
      .rsp_rollover_total      (rsp_rollover_total),
      .rsp_frame_header_total  (rsp_frame_header_total),
      .rsp_crc_header_total    (rsp_crc_header_total),
      .rsp_status_header_total (rsp_status_header_total),
      .rsp_upset_total         (rsp_upset_total),
      .rsp_spills_started      (rsp_spills_started),
      .rsp_spills_ended        (rsp_spills_ended),
      .rsp_spill_tag           (rsp_spill_tag),
      .rsp_end_missing         (rsp_end_missing)
   );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the spill word stream monitor core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STATUS_WORDS  = swsm_pkg::STATUS_WORDS_DEFAULT;
   localparam int RANDOM_WORDS  = 1950;
   localparam int CALM_WORDS    = 150;
   localparam int HOLD_AT_WORD  = 600;
   localparam int HOLD_CYCLES   = 300;
   localparam int RUN_LIMIT     = 500000;
   localparam int REPORT_LIMIT  = 10;

   localparam int WORD_W  = swsm_pkg::WORD_W;
   localparam int TOTAL_W = swsm_pkg::TOTAL_W;
   localparam int TAG_W   = swsm_pkg::TAG_W;

   typedef struct packed {
      logic [WORD_W-1:0]   word;
      logic                first;
      logic                last;
      logic                typed;     // class and end_missing below are fixed by hand
      swsm_pkg::class_type cls;
      logic                missing;
   } lane_word_type;

   typedef struct packed {
      swsm_pkg::class_type cls;
      logic [TOTAL_W-1:0]  rollover;
      logic [TOTAL_W-1:0]  frame;
      logic [TOTAL_W-1:0]  crc;
      logic [TOTAL_W-1:0]  status_hdr;
      logic [TOTAL_W-1:0]  upset;
      logic [TOTAL_W-1:0]  started;
      logic [TOTAL_W-1:0]  ended;
      logic [TAG_W-1:0]    tag;
      logic                missing;
   } tally_type;

   // Opening sequence: every class, window edges, repeated and early end markers,
   // implicit start, restart mid-spill, single-word spills, bad start words.
   localparam lane_word_type OPENING [25] = '{
      '{32'h7ABC1234, 1'b1, 1'b0, 1'b1, swsm_pkg::CLS_SOS,         1'b0},
      '{32'hFABC0000, 1'b0, 1'b0, 1'b1, swsm_pkg::CLS_DATA,        1'b0},
      '{swsm_pkg::WORD_RO,  1'b0, 1'b0, 1'b1, swsm_pkg::CLS_ROLLOVER,   1'b0},
      '{swsm_pkg::WORD_FH,  1'b0, 1'b0, 1'b1, swsm_pkg::CLS_FRAME,      1'b0},
      '{swsm_pkg::WORD_CRC, 1'b0, 1'b0, 1'b1, swsm_pkg::CLS_CRC,        1'b0},
      '{swsm_pkg::WORD_SH,  1'b0, 1'b0, 1'b1, swsm_pkg::CLS_STATUS_HDR, 1'b0},
      '{32'h00000000, 1'b0, 1'b0, 1'b1, swsm_pkg::CLS_STATUS_OK,   1'b0},
      '{32'hFFFFFFFF, 1'b0, 1'b0, 1'b1, swsm_pkg::CLS_UPSET,       1'b0},
      '{32'hFABC0000, 1'b0, 1'b0, 1'b1, swsm_pkg::CLS_EOS,         1'b0},
      '{32'h0000000F, 1'b0, 1'b0, 1'b1, swsm_pkg::CLS_UPSET,       1'b0},
      '{32'hFABC0000, 1'b0, 1'b0, 1'b1, swsm_pkg::CLS_EOS,         1'b0},
      '{32'h00000001, 1'b0, 1'b0, 1'b0, swsm_pkg::CLS_DATA,        1'b0},
      '{32'h12345670, 1'b0, 1'b0, 1'b0, swsm_pkg::CLS_DATA,        1'b0},
      '{32'h00000000, 1'b0, 1'b0, 1'b1, swsm_pkg::CLS_STATUS_OK,   1'b0},
      '{32'h00000000, 1'b0, 1'b1, 1'b1, swsm_pkg::CLS_DATA,        1'b0},
      '{32'h00000000, 1'b0, 1'b1, 1'b1, swsm_pkg::CLS_MISSING_SOS, 1'b1},
      '{32'h7FFF0000, 1'b1, 1'b1, 1'b1, swsm_pkg::CLS_SOS,         1'b1},
      '{32'h70010000, 1'b1, 1'b0, 1'b1, swsm_pkg::CLS_SOS,         1'b0},
      '{swsm_pkg::WORD_RO,  1'b0, 1'b0, 1'b1, swsm_pkg::CLS_ROLLOVER,   1'b0},
      '{32'h7002FFFF, 1'b1, 1'b0, 1'b1, swsm_pkg::CLS_SOS,         1'b0},
      '{swsm_pkg::WORD_SH,  1'b0, 1'b0, 1'b1, swsm_pkg::CLS_STATUS_HDR, 1'b0},
      '{swsm_pkg::WORD_FH,  1'b0, 1'b0, 1'b1, swsm_pkg::CLS_FRAME,      1'b0},
      '{32'hF0020000, 1'b0, 1'b1, 1'b1, swsm_pkg::CLS_EOS,         1'b0},
      '{32'h81230000, 1'b1, 1'b0, 1'b1, swsm_pkg::CLS_MISSING_SOS, 1'b0},
      '{32'hF1230000, 1'b0, 1'b1, 1'b1, swsm_pkg::CLS_DATA,        1'b1}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [WORD_W-1:0]    req_word;
   logic                 req_first_of_spill;
   logic                 req_last_of_spill;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [3:0]           rsp_word_class;
   logic [TOTAL_W-1:0]   rsp_rollover_total;
   logic [TOTAL_W-1:0]   rsp_frame_header_total;
   logic [TOTAL_W-1:0]   rsp_crc_header_total;
   logic [TOTAL_W-1:0]   rsp_status_header_total;
   logic [TOTAL_W-1:0]   rsp_upset_total;
   logic [TOTAL_W-1:0]   rsp_spills_started;
   logic [TOTAL_W-1:0]   rsp_spills_ended;
   logic [TAG_W-1:0]     rsp_spill_tag;
   logic                 rsp_end_missing;

   // Predictor state
   logic [TOTAL_W-1:0]          lane_totals [swsm_pkg::NUM_PEND];
   logic [swsm_pkg::PEND_W-1:0] spill_pending [swsm_pkg::NUM_PEND];
   logic [TOTAL_W-1:0]          started_total;
   logic [TOTAL_W-1:0]          ended_total;
   logic [swsm_pkg::STEP_W-1:0] window_step;
   logic [WORD_W-1:0]           end_marker;
   logic                        marker_seen;
   logic [1:0]                  word_pos;

   lane_word_type        word_plan [$];
   tally_type            expected_tallies [$];
   int                   error_count = 0;
   int                   result_count = 0;
   int                   cycle_count = 0;
   bit                   calm = 1'b0;
   bit                   hold_ask = 1'b0;
   bit                   hold_done = 1'b0;

   spill_word_stream_monitor_core #(
      .STATUS_WORDS (STATUS_WORDS)
   ) dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_word                (req_word),
      .req_first_of_spill      (req_first_of_spill),
      .req_last_of_spill       (req_last_of_spill),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_word_class          (rsp_word_class),
      .rsp_rollover_total      (rsp_rollover_total),
      .rsp_frame_header_total  (rsp_frame_header_total),
      .rsp_crc_header_total    (rsp_crc_header_total),
      .rsp_status_header_total (rsp_status_header_total),
      .rsp_upset_total         (rsp_upset_total),
      .rsp_spills_started      (rsp_spills_started),
      .rsp_spills_ended        (rsp_spills_ended),
      .rsp_spill_tag           (rsp_spill_tag),
      .rsp_end_missing         (rsp_end_missing)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [TOTAL_W-1:0] sat_bump(logic [TOTAL_W-1:0] count);
      return (count == swsm_pkg::TOTAL_MAX) ? count : count + 1'b1;
   endfunction

   function automatic void pending_bump(int slot);
      if (spill_pending[slot] != swsm_pkg::PEND_MAX)
         spill_pending[slot] = spill_pending[slot] + 1'b1;
   endfunction

   function automatic void drop_pending();
      int k;
      for (k = 0; k < swsm_pkg::NUM_PEND; k++)
         spill_pending[k] = '0;
   endfunction

   function automatic void fold_pending();
      logic [TOTAL_W:0] sum;
      int k;
      for (k = 0; k < swsm_pkg::NUM_PEND; k++) begin
         sum = {1'b0, lane_totals[k]} + (TOTAL_W+1)'(spill_pending[k]);
         lane_totals[k] = sum[TOTAL_W] ? swsm_pkg::TOTAL_MAX : sum[TOTAL_W-1:0];
         spill_pending[k] = '0;
      end
   endfunction

   function automatic void clear_predictor();
      int k;
      for (k = 0; k < swsm_pkg::NUM_PEND; k++)
         lane_totals[k] = '0;
      drop_pending();
      started_total = '0;
      ended_total = '0;
      window_step = '0;
      end_marker = '0;
      marker_seen = 1'b0;
      word_pos = '0;
   endfunction

   // Classify one word, update the spill bookkeeping and return the totals after it.
   function automatic tally_type tally_word(logic [WORD_W-1:0] w, logic first, logic last);
      tally_type           r;
      swsm_pkg::class_type cls;
      logic                miss;
      logic                hit_end;
      cls = swsm_pkg::CLS_DATA;
      miss = 1'b0;
      if (first || word_pos == 2'd0) begin
         drop_pending();
         window_step = '0;
         marker_seen = 1'b0;
         word_pos = '0;
         end_marker = {swsm_pkg::EOS_NIBBLE, w[27:16], 16'h0000};
         if (w[31:28] == swsm_pkg::SOS_NIBBLE) begin
            cls = swsm_pkg::CLS_SOS;
            started_total = sat_bump(started_total);
         end else begin
            cls = swsm_pkg::CLS_MISSING_SOS;
         end
      end else if (w == swsm_pkg::WORD_RO) begin
         cls = swsm_pkg::CLS_ROLLOVER;
         pending_bump(swsm_pkg::P_RO);
         window_step = '0;
      end else if (w == swsm_pkg::WORD_FH) begin
         cls = swsm_pkg::CLS_FRAME;
         pending_bump(swsm_pkg::P_FH);
         window_step = '0;
      end else if (w == swsm_pkg::WORD_CRC) begin
         cls = swsm_pkg::CLS_CRC;
         pending_bump(swsm_pkg::P_CRC);
         window_step = '0;
      end else if (w == swsm_pkg::WORD_SH) begin
         cls = swsm_pkg::CLS_STATUS_HDR;
         pending_bump(swsm_pkg::P_SH);
         window_step = swsm_pkg::STEP_W'(1);
      end else begin
         hit_end = (word_pos == 2'd2) && (w == end_marker);
         if (hit_end) begin
            fold_pending();
            if (!marker_seen)
               ended_total = sat_bump(ended_total);
            marker_seen = 1'b1;
            cls = swsm_pkg::CLS_EOS;
         end
         if (window_step >= 1 && window_step <= STATUS_WORDS) begin
            // upset found alongside an end marker lands after the commit
            if (w[3:0] != 4'h0) begin
               pending_bump(swsm_pkg::P_UPSET);
               if (!hit_end)
                  cls = swsm_pkg::CLS_UPSET;
            end else if (!hit_end) begin
               cls = swsm_pkg::CLS_STATUS_OK;
            end
            window_step = (window_step == STATUS_WORDS) ? '0 : window_step + 1'b1;
         end else begin
            window_step = '0;
         end
      end
      if (word_pos < 2'd2)
         word_pos = word_pos + 1'b1;
      if (last) begin
         if (!marker_seen) begin
            fold_pending();
            miss = 1'b1;
         end
         drop_pending();
         window_step = '0;
         word_pos = '0;
      end
      r = '{cls, lane_totals[swsm_pkg::P_RO], lane_totals[swsm_pkg::P_FH],
            lane_totals[swsm_pkg::P_CRC], lane_totals[swsm_pkg::P_SH],
            lane_totals[swsm_pkg::P_UPSET], started_total, ended_total,
            end_marker[27:16], miss};
      return r;
   endfunction

   function automatic void add_word(logic [WORD_W-1:0] w, logic first, logic last);
      lane_word_type row;
      row = '{w, first, last, 1'b0, swsm_pkg::CLS_DATA, 1'b0};
      word_plan.push_back(row);
   endfunction

   // Mostly well-formed spills with random content; some noise and broken framing.
   task automatic plan_spill();
      logic [TAG_W-1:0]  tag;
      logic [WORD_W-1:0] w;
      logic              first;
      int                pick;
      int                body;
      int                i;
      tag = TAG_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         repeat ($urandom_range(1, 12))
            add_word($urandom, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
         return;
      end
      w = {swsm_pkg::SOS_NIBBLE, tag, 16'($urandom)};
      if (pick < 15)
         w[31:28] = 4'($urandom);
      first = !(pick >= 15 && pick < 25);
      body = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 40);
      add_word(w, first, body == 0);
      for (i = 1; i <= body; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            w = swsm_pkg::WORD_RO;
         end else if (pick < 12) begin
            w = swsm_pkg::WORD_FH;
         end else if (pick < 18) begin
            w = swsm_pkg::WORD_CRC;
         end else if (pick < 26) begin
            w = swsm_pkg::WORD_SH;
         end else if (pick < 36) begin
            w = {swsm_pkg::EOS_NIBBLE, tag, 16'h0000};
         end else if (pick < 41) begin
            // near miss on the end marker
            w = {swsm_pkg::EOS_NIBBLE, tag, 16'h0000};
            w[$urandom_range(0, 31)] ^= 1'b1;
         end else if (pick < 75) begin
            w = $urandom;
            if ($urandom_range(0, 2) != 0)
               w[3:0] = 4'h0;
         end else begin
            w = $urandom;
         end
         // leave an occasional spill open so the next start restarts it
         add_word(w, 1'b0, i == body && $urandom_range(0, 19) != 0);
      end
   endtask

   // Sender
   initial begin
      lane_word_type row;
      tally_type     want;
      int            idx;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_word <= '0;
      req_first_of_spill <= 1'b0;
      req_last_of_spill <= 1'b0;
      clear_predictor();
      foreach (OPENING[i])
         word_plan.push_back(OPENING[i]);
      while (word_plan.size() < $size(OPENING) + RANDOM_WORDS)
         plan_spill();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (idx = 0; idx < word_plan.size(); idx++) begin
         row = word_plan[idx];
         if (idx >= word_plan.size() - CALM_WORDS)
            calm = 1'b1;
         if (idx == HOLD_AT_WORD)
            hold_ask = 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_word <= row.word;
         req_first_of_spill <= row.first;
         req_last_of_spill <= row.last;
         @(posedge clock);
         while (req_stall)
            @(posedge clock);
         want = tally_word(row.word, row.first, row.last);
         if (row.typed) begin
            want.cls = row.cls;
            want.missing = row.missing;
         end
         expected_tallies.push_back(want);
      end
      req_valid <= 1'b0;
      while (expected_tallies.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_tallies.size() == 0)
         $display("spill_word_stream_monitor_core regression: pass");
      else
         $display("spill_word_stream_monitor_core regression: fail");
      $finish;
   end

   // Receiver: random stall bursts, one long hold-off to back the block up
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_results
      tally_type seen;
      tally_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{swsm_pkg::class_type'(rsp_word_class), rsp_rollover_total,
                  rsp_frame_header_total, rsp_crc_header_total, rsp_status_header_total,
                  rsp_upset_total, rsp_spills_started, rsp_spills_ended, rsp_spill_tag,
                  rsp_end_missing};
         if (expected_tallies.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("result %0d arrived with nothing expected", result_count);
         end else begin
            want = expected_tallies.pop_front();
            if (seen !== want) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("result %0d mismatch (expected / actual):", result_count);
                  $display("  class %0d / %0d  tag %h / %h  end_missing %b / %b",
                           want.cls, seen.cls, want.tag, seen.tag,
                           want.missing, seen.missing);
                  $display("  rollover %h / %h  frame %h / %h  crc %h / %h",
                           want.rollover, seen.rollover, want.frame, seen.frame,
                           want.crc, seen.crc);
                  $display("  status %h / %h  upset %h / %h",
                           want.status_hdr, seen.status_hdr, want.upset, seen.upset);
                  $display("  started %h / %h  ended %h / %h",
                           want.started, seen.started, want.ended, seen.ended);
               end
            end
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("spill_word_stream_monitor_core regression: fail");
         $finish;
      end
   end

endmodule

FILE: sim.f
hdl/swsm_pkg.sv
hdl/swsm_front.sv
hdl/swsm_queue.sv
hdl/swsm_back.sv
hdl/spill_word_stream_monitor_core.sv
tb/testbench.sv
